// ----- rtl/aal5s_pkg.sv -----
`default_nettype none

package aal5s_pkg;

	localparam int VPI_W         = 8;
	localparam int VCI_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;
	localparam int LEN_W         = 16;
	localparam int CRC_W         = 32;
	localparam int WORD_W        = 64;
	localparam int HDR_W         = 32;
	localparam int HEC_W         = 8;
	localparam int BYTE_POS_W    = 3;
	localparam int PAYLOAD_WORDS = 6;
	localparam int WORD_IDX_W    = 3;
	localparam int BUF_WORDS     = 16;
	localparam int BUF_PTR_W     = 4;
	localparam int BUF_CNT_W     = 5;
	localparam int FLAG_DEPTH    = 4;
	localparam int FLAG_PTR_W    = 2;

	localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(PAYLOAD_WORDS - 1);
	localparam logic [BYTE_POS_W-1:0] LAST_BYTE = '1;
	localparam logic [LEN_W-1:0]      LEN_MAX   = '1;
	localparam logic [CRC_W-1:0]      CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0]      CRC_POLY  = 32'h04C1_1DB7;
	localparam logic [HEC_W-1:0]      HEC_POLY  = 8'h07;
	localparam logic [HEC_W-1:0]      HEC_XOR   = 8'h55;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VPI = 1'b0,
		CFG_VCI = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] data;
	} buf_wr_t;

	typedef struct packed {
		logic valid;
		logic packet_end;
		logic too_long;
		logic run_last;
	} cell_commit_t;

	typedef struct packed {
		logic packet_end;
		logic too_long;
		logic run_last;
	} cell_flags_t;

	typedef logic [CRC_W-1:0][CRC_W+WORD_W-1:0] crc_masks_t;
	typedef logic [HEC_W-1:0][HDR_W-1:0]        hec_masks_t;

	// msb-first lfsr run symbolically: each state bit as a mask over {data, crc}
	function automatic crc_masks_t crc_masks(input int nbits);
		crc_masks_t                s;
		logic [CRC_W+WORD_W-1:0]   fb;
		for (int i = 0; i < CRC_W; i++) begin
			s[i]    = '0;
			s[i][i] = 1'b1;
		end
		for (int k = 0; k < nbits; k++) begin
			fb = s[CRC_W-1];
			fb[CRC_W + WORD_W - 1 - k] = ~fb[CRC_W + WORD_W - 1 - k];
			for (int i = CRC_W - 1; i > 0; i--) begin
				s[i] = s[i-1] ^ (CRC_POLY[i] ? fb : '0);
			end
			s[0] = CRC_POLY[0] ? fb : '0;
		end
		return s;
	endfunction

	function automatic hec_masks_t hec_masks();
		hec_masks_t       s;
		logic [HDR_W-1:0] fb;
		s = '0;
		for (int k = 0; k < HDR_W; k++) begin
			fb = s[HEC_W-1];
			fb[HDR_W-1-k] = ~fb[HDR_W-1-k];
			for (int i = HEC_W - 1; i > 0; i--) begin
				s[i] = s[i-1] ^ (HEC_POLY[i] ? fb : '0);
			end
			s[0] = HEC_POLY[0] ? fb : '0;
		end
		return s;
	endfunction

	localparam crc_masks_t CRC_WORD_MASKS = crc_masks(WORD_W);
	localparam crc_masks_t CRC_HALF_MASKS = crc_masks(WORD_W / 2);
	localparam hec_masks_t HEC_MASKS      = hec_masks();

	// data is consumed from bit 63 down
	function automatic logic [CRC_W-1:0] crc_apply(input crc_masks_t m,
			input logic [CRC_W-1:0] crc, input logic [WORD_W-1:0] data);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = ^({data, crc} & m[i]);
		end
		return r;
	endfunction

	function automatic logic [HEC_W-1:0] hec_of(input logic [HDR_W-1:0] hdr);
		logic [HEC_W-1:0] r;
		for (int i = 0; i < HEC_W; i++) begin
			r[i] = ^(hdr & HEC_MASKS[i]);
		end
		return r ^ HEC_XOR;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aal5s_if.sv -----
`default_nettype none

interface aal5s_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface aal5s_cell_if;
	logic        valid;
	logic        ready;
	logic [31:0] cell_header;
	logic [7:0]  header_check;
	logic [63:0] payload_word;
	logic [2:0]  word_index;
	logic        cell_done;
	logic        packet_done;
	logic        too_long;
	logic        run_last;

	modport source (output valid, output cell_header, output header_check,
		output payload_word, output word_index, output cell_done, output packet_done,
		output too_long, output run_last, input ready);
	modport sink (input valid, input cell_header, input header_check,
		input payload_word, input word_index, input cell_done, input packet_done,
		input too_long, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/aal5s_asm.sv -----
`default_nettype none

module aal5s_asm import aal5s_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	aal5s_byte_if.sink   packet,
	input  logic         full,
	output buf_wr_t      wr,
	output cell_commit_t cm
);

	logic [7:0]            byte_s1;
	logic                  eop_s1;
	logic                  valid_s1;

	logic [WORD_W-1:0]     acc_q;
	logic [BYTE_POS_W-1:0] bpos_q;
	logic [WORD_IDX_W-1:0] wpos_q;
	logic [CRC_W-1:0]      crc_q;
	logic [LEN_W-1:0]      len_q;
	logic                  ovf_q;
	logic                  pad_q;

	logic                  take;
	logic                  step_pad;
	logic                  word_done;
	logic                  wpos_last;
	logic [5:0]            lane_lsb;
	logic [WORD_W-1:0]     word_new;
	logic [CRC_W-1:0]      crc_half;
	logic [WORD_W-1:0]     trailer_word;

	assign take      = valid_s1 && !pad_q && !full;
	assign step_pad  = pad_q && !full;
	assign word_done = take && (bpos_q == LAST_BYTE || eop_s1);
	assign wpos_last = wpos_q == LAST_WORD;
	assign lane_lsb  = {~bpos_q, 3'b000};

	assign packet.ready = !valid_s1 || take;

	always_comb begin
		word_new = (bpos_q == '0) ? '0 : acc_q;
		word_new[lane_lsb +: 8] = byte_s1;
	end

	// uu and cpi zero, then length, then the complemented crc
	assign crc_half     = crc_apply(CRC_HALF_MASKS, crc_q, {16'h0000, len_q, 32'h0000_0000});
	assign trailer_word = {16'h0000, len_q, ~crc_half};

	always_comb begin
		wr.valid      = word_done || step_pad;
		wr.data       = pad_q ? (wpos_last ? trailer_word : '0) : word_new;
		cm.valid      = wr.valid && wpos_last;
		cm.packet_end = pad_q;
		cm.too_long   = pad_q && ovf_q;
		cm.run_last   = pad_q || !eop_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			bpos_q   <= '0;
			wpos_q   <= '0;
			crc_q    <= CRC_INIT;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			pad_q    <= 1'b0;
		end else begin
			if (packet.ready) begin
				valid_s1 <= packet.valid;
			end
			if (take) begin
				bpos_q <= eop_s1 ? '0 : bpos_q + 1'b1;
				len_q  <= len_q + 1'b1;
				ovf_q  <= ovf_q || (len_q == LEN_MAX);
				if (word_done) begin
					crc_q  <= crc_apply(CRC_WORD_MASKS, crc_q, word_new);
					wpos_q <= wpos_last ? '0 : wpos_q + 1'b1;
				end
				if (eop_s1) begin
					pad_q <= 1'b1;
				end
			end else if (step_pad) begin
				if (wpos_last) begin
					crc_q  <= CRC_INIT;
					len_q  <= '0;
					ovf_q  <= 1'b0;
					pad_q  <= 1'b0;
					wpos_q <= '0;
				end else begin
					crc_q  <= crc_apply(CRC_WORD_MASKS, crc_q, '0);
					wpos_q <= wpos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (packet.valid && packet.ready) begin
			byte_s1 <= packet.data_byte;
			eop_s1  <= packet.end_of_packet;
		end
		if (take) begin
			acc_q <= word_new;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aal5s_cellq.sv -----
`default_nettype none

module aal5s_cellq import aal5s_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VPI_W-1:0]  vpi,
	input  logic [VCI_W-1:0]  vci,
	input  buf_wr_t           wr,
	input  cell_commit_t      cm,
	output logic              full,
	aal5s_cell_if.source      cells
);

	logic [WORD_W-1:0]     mem_q [BUF_WORDS];
	cell_flags_t           flg_q [FLAG_DEPTH];

	logic [BUF_PTR_W-1:0]  wptr_q;
	logic [BUF_PTR_W-1:0]  rptr_q;
	logic [BUF_CNT_W-1:0]  used_q;
	logic [BUF_CNT_W-1:0]  avail_q;
	logic [FLAG_PTR_W-1:0] fw_q;
	logic [FLAG_PTR_W-1:0] fr_q;
	logic [WORD_IDX_W-1:0] oidx_q;

	logic                  out_valid_q;
	logic [HDR_W-1:0]      header_q;
	logic [HEC_W-1:0]      hec_q;
	logic [WORD_W-1:0]     word_q;
	logic [WORD_IDX_W-1:0] idx_q;
	logic                  cell_done_q;
	logic                  packet_done_q;
	logic                  too_long_q;
	logic                  run_last_q;

	logic                  pop;
	logic                  oidx_last;
	cell_flags_t           head;
	logic [HDR_W-1:0]      hdr;

	assign full      = used_q == BUF_CNT_W'(BUF_WORDS);
	assign pop       = (avail_q != '0) && (!out_valid_q || cells.ready);
	assign oidx_last = oidx_q == LAST_WORD;
	assign head      = flg_q[fr_q];
	assign hdr       = {4'h0, vpi, vci, 2'b00, head.packet_end, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			used_q      <= '0;
			avail_q     <= '0;
			fw_q        <= '0;
			fr_q        <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (cm.valid) begin
				fw_q <= fw_q + 1'b1;
			end
			used_q  <= used_q + BUF_CNT_W'(wr.valid) - BUF_CNT_W'(pop);
			// words become visible only once their cell is complete
			avail_q <= avail_q + (cm.valid ? BUF_CNT_W'(PAYLOAD_WORDS) : '0)
				- BUF_CNT_W'(pop);
			if (pop) begin
				rptr_q      <= rptr_q + 1'b1;
				oidx_q      <= oidx_last ? '0 : oidx_q + 1'b1;
				out_valid_q <= 1'b1;
				if (oidx_last) begin
					fr_q <= fr_q + 1'b1;
				end
			end else if (cells.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wptr_q] <= wr.data;
		end
		if (cm.valid) begin
			flg_q[fw_q] <= '{packet_end: cm.packet_end, too_long: cm.too_long,
				run_last: cm.run_last};
		end
		if (pop) begin
			header_q      <= hdr;
			hec_q         <= hec_of(hdr);
			word_q        <= mem_q[rptr_q];
			idx_q         <= oidx_q;
			cell_done_q   <= oidx_last;
			packet_done_q <= head.packet_end;
			too_long_q    <= head.too_long;
			run_last_q    <= oidx_last && head.run_last;
		end
	end

	assign cells.valid        = out_valid_q;
	assign cells.cell_header  = header_q;
	assign cells.header_check = hec_q;
	assign cells.payload_word = word_q;
	assign cells.word_index   = idx_q;
	assign cells.cell_done    = cell_done_q;
	assign cells.packet_done  = packet_done_q;
	assign cells.too_long     = too_long_q;
	assign cells.run_last     = run_last_q;

endmodule

`default_nettype wire

// ----- rtl/aal5_segmentation_core.sv -----
`default_nettype none

// AAL5 segmentation: packet bytes come in on packet, one per cycle when not held,
// and ATM cells leave on cells as six 64-bit payload words each, one word per cycle
// while cells.ready is high, with the header and HEC beside every word. While a
// cell fills, a byte is taken every cycle unless the 16-word cell queue is full;
// the byte that ends a packet holds the input as the assembler writes the zero
// padding and the trailer word into the queue, one word a cycle when not full. A
// word leaves through the output register once its cell completes. Throughput is
// bounded by the output taking one word per cycle. VPI and VCI must be written on
// the configuration port while no packet is in flight; the block does not check.
module aal5_segmentation_core import aal5s_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	aal5s_byte_if.sink            packet,
	aal5s_cell_if.source          cells
);

	logic [VPI_W-1:0] vpi_q;
	logic [VCI_W-1:0] vci_q;
	buf_wr_t          buf_wr;
	cell_commit_t     commit;
	logic             buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpi_q <= '0;
			vci_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_VPI: vpi_q <= cfg_data[VPI_W-1:0];
				CFG_VCI: vci_q <= cfg_data[VCI_W-1:0];
				default: ;
			endcase
		end
	end

	aal5s_asm u_asm (
		.clk    (clk),
		.arst_n (arst_n),
		.packet (packet),
		.full   (buf_full),
		.wr     (buf_wr),
		.cm     (commit)
	);

	aal5s_cellq u_cellq (
		.clk    (clk),
		.arst_n (arst_n),
		.vpi    (vpi_q),
		.vci    (vci_q),
		.wr     (buf_wr),
		.cm     (commit),
		.full   (buf_full),
		.cells  (cells)
	);

endmodule

`default_nettype wire

// ----- rtl/aal5s_checker.sv -----
`default_nettype none

module aal5s_checker import aal5s_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [WORD_IDX_W-1:0] word_index,
	input logic                  cell_done,
	input logic                  packet_done,
	input logic                  too_long,
	input logic                  run_last,
	input logic [WORD_W-1:0]     payload_word
);

	logic [WORD_IDX_W-1:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= (exp_idx_q == LAST_WORD) ? '0 : exp_idx_q + 1'b1;
		end
	end

	// words of a cell leave in order, cells never cut short
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_index == exp_idx_q)
		else $error("word out of cell order");

	a_cell_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_done == (word_index == LAST_WORD))
		else $error("cell end mark misplaced");

	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last |-> cell_done)
		else $error("run end inside a cell");

	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> packet_done)
		else $error("length flag outside final cell");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_word))
		else $error("stalled item changed");

endmodule

bind aal5_segmentation_core aal5s_checker u_aal5s_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (cells.valid),
	.out_ready    (cells.ready),
	.word_index   (cells.word_index),
	.cell_done    (cells.cell_done),
	.packet_done  (cells.packet_done),
	.too_long     (cells.too_long),
	.run_last     (cells.run_last),
	.payload_word (cells.payload_word)
);

`default_nettype wire
